@@ hdl/mld_pkg.sv @@
// Package for the mouse-look direction block: constants, state codes,
// CORDIC control structs and the constant tables. No dependencies.
package mld_pkg;

	localparam int YAW_FULL   = 92160;
	localparam int PITCH_MAX  = 23040;
	localparam int ONE_Q14    = 16384;
	localparam int CORDIC_GAIN = 652032874;
	localparam int TABLE_LEN  = 24;
	localparam int ATAN_IW    = 5;

	// floor(a / 45) = (a * DIV45_MUL) >> DIV45_SHIFT, exact for a below 2^17
	localparam int DIV45_MUL   = 186414;
	localparam int DIV45_SHIFT = 23;
	localparam int TURN_SHIFT  = 21;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_SENS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLIM   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IYAW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IPITCH = 3'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MDX,
		ST_MDY,
		ST_PITCH,
		ST_RED,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_CWAIT,
		ST_MX,
		ST_MZ,
		ST_FIN
	} mld_state_t;

	typedef struct packed {
		logic               start;
		logic [1:0]         quad;
		logic signed [31:0] z;
	} mld_cmd_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] cosv;
		logic signed [31:0] sinv;
	} mld_sts_t;

	// atan(2^-i) as a fraction of a full turn, 2^32 per turn
	function automatic logic [29:0] atan_turn(input logic [ATAN_IW-1:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'h20000000;
			5'd1:  v = 30'h12E4051E;
			5'd2:  v = 30'h09FB385B;
			5'd3:  v = 30'h051111D4;
			5'd4:  v = 30'h028B0D43;
			5'd5:  v = 30'h0145D7E1;
			5'd6:  v = 30'h00A2F61E;
			5'd7:  v = 30'h00517C55;
			5'd8:  v = 30'h0028BE53;
			5'd9:  v = 30'h00145F2F;
			5'd10: v = 30'h000A2F98;
			5'd11: v = 30'h000517CC;
			5'd12: v = 30'h00028BE6;
			5'd13: v = 30'h000145F3;
			5'd14: v = 30'h0000A2FA;
			5'd15: v = 30'h0000517D;
			5'd16: v = 30'h000028BE;
			5'd17: v = 30'h0000145F;
			5'd18: v = 30'h00000A30;
			5'd19: v = 30'h00000518;
			5'd20: v = 30'h0000028C;
			5'd21: v = 30'h00000146;
			5'd22: v = 30'h000000A3;
			5'd23: v = 30'h00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

	// floor(r * 2^21 / 45) for r below 45; 2^21 = 45 * 46603 + 17
	function automatic logic [20:0] rem_turn(input logic [5:0] r);
		logic [4:0] f;
		case (r)
			6'd0, 6'd1, 6'd2:    f = 5'd0;
			6'd3, 6'd4, 6'd5:    f = 5'd1;
			6'd6, 6'd7:          f = 5'd2;
			6'd8, 6'd9, 6'd10:   f = 5'd3;
			6'd11, 6'd12, 6'd13: f = 5'd4;
			6'd14, 6'd15:        f = 5'd5;
			6'd16, 6'd17, 6'd18: f = 5'd6;
			6'd19, 6'd20, 6'd21: f = 5'd7;
			6'd22, 6'd23:        f = 5'd8;
			6'd24, 6'd25, 6'd26: f = 5'd9;
			6'd27, 6'd28, 6'd29: f = 5'd10;
			6'd30, 6'd31:        f = 5'd11;
			6'd32, 6'd33, 6'd34: f = 5'd12;
			6'd35, 6'd36, 6'd37: f = 5'd13;
			6'd38, 6'd39:        f = 5'd14;
			6'd40, 6'd41, 6'd42: f = 5'd15;
			6'd43, 6'd44:        f = 5'd16;
			default:             f = 5'd0;
		endcase
		return 21'(r) * 21'(46603) + 21'(f);
	endfunction

endpackage

@@ hdl/mld_ifs.sv @@
// Handshake channels of the mouse-look direction block: pointer words,
// configuration writes and result words. Depends on mld_pkg.
interface mld_ptr_if #(parameter int POS_BITS = 12) ();
	logic                valid;
	logic                ready;
	logic [POS_BITS-1:0] pointer_x;
	logic [POS_BITS-1:0] pointer_y;
	modport source(output valid, output pointer_x, output pointer_y, input ready);
	modport sink(input valid, input pointer_x, input pointer_y, output ready);
endinterface

interface mld_cfg_if import mld_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

interface mld_res_if ();
	logic               valid;
	logic               ready;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic [16:0]        yaw_now;
	logic signed [15:0] pitch_now;
	modport source(output valid, output dir_x, output dir_y, output dir_z,
		output yaw_now, output pitch_now, input ready);
	modport sink(input valid, input dir_x, input dir_y, input dir_z,
		input yaw_now, input pitch_now, output ready);
endinterface

@@ hdl/mouse_look_direction.sv @@
// Mouse-look camera direction: pointer words in, unit view vector words out.
// Each pointer word is worked through before the block accepts the next one;
// the work is the shared CORDIC unit, run once for pitch and once for yaw,
// plus the shared 32x32 multiplier steps and the yaw wrap, one conditional
// subtract per cycle. A finished result waits in the output register while
// the next word is accepted. Configuration writes take effect at once;
// initial_yaw and initial_pitch also load the current angles. Depends on
// mld_pkg, mld_ifs and mld_cordic.
module mouse_look_direction import mld_pkg::*; #(
	parameter int POS_BITS     = 12,
	parameter int CORDIC_STEPS = 16
) (
	input logic        clk,
	input logic        arst_n,
	mld_ptr_if.sink    pointer,
	mld_cfg_if.sink    cfg,
	mld_res_if.source  result
);

	localparam int SW   = POS_BITS + 10;
	localparam int VW   = POS_BITS + 11;
	localparam int KTOP = POS_BITS - 7;
	localparam int KW   = $clog2(KTOP + 1);
	localparam logic [VW:0] YOFF = (VW + 1)'(YAW_FULL) << (POS_BITS - 8);
	localparam logic signed [63:0] RND46 = 64'sd1 <<< 45;
	localparam logic signed [63:0] RND16 = 64'sd1 <<< 16 - 1;

	mld_state_t state_q, state_d;

	// control and angle state
	logic [15:0]        sens_q;
	logic [14:0]        plim_q;
	logic [16:0]        yaw_q;
	logic signed [15:0] pitch_q;
	logic               first_q;
	logic               sel_q;
	logic [KW-1:0]      k_q;
	logic               ovalid_q;

	// datapath
	logic [POS_BITS-1:0]  last_x_q;
	logic [POS_BITS-1:0]  last_y_q;
	logic signed [POS_BITS:0] dx_q;
	logic signed [POS_BITS:0] dy_q;
	logic [VW-1:0]        red_q;
	logic [10:0]          qa_q;
	logic signed [63:0]   p_q;
	logic signed [31:0]   cp_q;
	logic signed [31:0]   sp_q;
	logic signed [31:0]   cy_q;
	logic signed [31:0]   sy_q;
	logic signed [15:0]   dirx_q;
	logic signed [15:0]   o_dx_q;
	logic signed [15:0]   o_dy_q;
	logic signed [15:0]   o_dz_q;
	logic [16:0]          o_yaw_q;
	logic signed [15:0]   o_pitch_q;

	logic               mul_en;
	logic signed [31:0] ma;
	logic signed [31:0] mb;
	mld_cmd_t           ccmd;
	mld_sts_t           csts;

	logic                  accept;
	logic                  load_out;
	logic [POS_BITS-1:0]   lx;
	logic [POS_BITS-1:0]   ly;
	logic signed [63:0]    stp64;
	logic signed [SW-1:0]  step;
	logic signed [VW:0]    ysum;
	logic [VW-1:0]         kval;
	logic [VW-1:0]         red_nx;
	logic [14:0]           lim;
	logic signed [SW:0]    psum;
	logic signed [SW:0]    plim_s;
	logic signed [15:0]    pclamp;
	logic [16:0]           pwrap;
	logic [16:0]           ang;
	logic [16:0]           ra17;
	logic [31:0]           turn;
	logic [31:0]           tq;
	logic [1:0]            quad;
	logic [31:0]           rbits;
	logic signed [63:0]    rx;
	logic signed [63:0]    ry;
	logic [16:0]           iyaw;

	function automatic logic signed [15:0] sat14(input logic signed [63:0] r);
		logic signed [15:0] v;
		if (r > 64'sd16384)
			v = 16'(ONE_Q14);
		else if (r < -64'sd16384)
			v = -16'(ONE_Q14);
		else
			v = r[15:0];
		return v;
	endfunction

	mld_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ccmd),
		.sts    (csts)
	);

	assign accept   = pointer.valid && pointer.ready;
	assign load_out = (state_q == ST_FIN) && (!ovalid_q || result.ready);
	assign lx = first_q ? pointer.pointer_x : last_x_q;
	assign ly = first_q ? pointer.pointer_y : last_y_q;

	// angle step, rounded half up
	assign stp64 = (p_q + 64'sd128) >>> 8;
	assign step  = stp64[SW-1:0];

	assign ysum   = signed'({{(VW - 16){1'b0}}, yaw_q}) + (VW + 1)'(step) + signed'(YOFF);
	assign kval   = VW'(YAW_FULL) << k_q;
	assign red_nx = (red_q >= kval) ? red_q - kval : red_q;

	assign lim    = (plim_q > 15'(PITCH_MAX)) ? 15'(PITCH_MAX) : plim_q;
	assign plim_s = signed'({{(SW + 1 - 15){1'b0}}, lim});
	assign psum   = (SW + 1)'(pitch_q) + (SW + 1)'(step);
	always_comb begin
		if (psum > plim_s)
			pclamp = plim_s[15:0];
		else if (psum < -plim_s)
			pclamp = 16'(-plim_s);
		else
			pclamp = psum[15:0];
	end

	// angle to turn fraction: floor(a * 2^32 / 92160) = (a/45) << 21 + rem
	assign pwrap = pitch_q[15] ? ({pitch_q[15], pitch_q} + 17'(YAW_FULL)) : {1'b0, pitch_q};
	assign ang   = sel_q ? yaw_q : pwrap;
	assign ra17  = ang - p_q[16:0];
	assign turn  = {qa_q, {TURN_SHIFT{1'b0}}} + {11'b0, rem_turn(ra17[5:0])};
	assign tq    = turn + 32'h2000_0000;
	assign quad  = tq[31:30];
	assign rbits = turn - {quad, 30'b0};

	assign rx = (p_q + RND46) >>> 46;
	assign ry = (64'(sp_q) + RND16) >>> 16;

	assign iyaw = (cfg.data >= 17'(YAW_FULL)) ? cfg.data - 17'(YAW_FULL) : cfg.data;

	assign pointer.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;

	assign result.valid     = ovalid_q;
	assign result.dir_x     = o_dx_q;
	assign result.dir_y     = o_dy_q;
	assign result.dir_z     = o_dz_q;
	assign result.yaw_now   = o_yaw_q;
	assign result.pitch_now = o_pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		mul_en     = 1'b0;
		ma         = '0;
		mb         = '0;
		ccmd.start = 1'b0;
		ccmd.quad  = quad;
		ccmd.z     = signed'(rbits);
		case (state_q)
			ST_IDLE: begin
				if (pointer.valid)
					state_d = ST_MDX;
			end
			ST_MDX: begin
				mul_en  = 1'b1;
				ma      = 32'(dx_q);
				mb      = signed'({16'b0, sens_q});
				state_d = ST_MDY;
			end
			ST_MDY: begin
				mul_en  = 1'b1;
				ma      = 32'(dy_q);
				mb      = signed'({16'b0, sens_q});
				state_d = ST_PITCH;
			end
			ST_PITCH: begin
				state_d = ST_RED;
			end
			ST_RED: begin
				if (k_q == '0)
					state_d = ST_T1;
			end
			ST_T1: begin
				mul_en  = 1'b1;
				ma      = signed'({15'b0, ang});
				mb      = 32'(DIV45_MUL);
				state_d = ST_T2;
			end
			ST_T2: begin
				mul_en  = 1'b1;
				ma      = signed'({21'b0, p_q[DIV45_SHIFT+10:DIV45_SHIFT]});
				mb      = 32'sd45;
				state_d = ST_T3;
			end
			ST_T3: begin
				ccmd.start = 1'b1;
				state_d    = ST_CWAIT;
			end
			ST_CWAIT: begin
				if (csts.done)
					state_d = sel_q ? ST_MX : ST_T1;
			end
			ST_MX: begin
				mul_en  = 1'b1;
				ma      = cp_q;
				mb      = cy_q;
				state_d = ST_MZ;
			end
			ST_MZ: begin
				mul_en  = 1'b1;
				ma      = cp_q;
				mb      = sy_q;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!ovalid_q || result.ready)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q   <= 16'd1311;
			plim_q   <= 15'd22784;
			yaw_q    <= '0;
			pitch_q  <= '0;
			first_q  <= 1'b1;
			sel_q    <= 1'b0;
			k_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out)
				ovalid_q <= 1'b1;
			else if (result.ready)
				ovalid_q <= 1'b0;
			if (accept)
				first_q <= 1'b0;
			case (state_q)
				ST_PITCH: begin
					pitch_q <= pclamp;
					k_q     <= KW'(KTOP);
					sel_q   <= 1'b0;
				end
				ST_RED: begin
					if (k_q == '0)
						yaw_q <= red_nx[16:0];
					else
						k_q <= k_q - 1'b1;
				end
				ST_CWAIT: begin
					if (csts.done)
						sel_q <= 1'b1;
				end
				default: begin
				end
			endcase
			if (cfg.valid) begin
				case (cfg.index)
					CFG_SENS:   sens_q  <= cfg.data[15:0];
					CFG_PLIM:   plim_q  <= cfg.data[14:0];
					CFG_IYAW:   yaw_q   <= iyaw;
					CFG_IPITCH: pitch_q <= cfg.data[15:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			p_q <= ma * mb;
		if (accept) begin
			dx_q     <= signed'({1'b0, pointer.pointer_x}) - signed'({1'b0, lx});
			dy_q     <= signed'({1'b0, ly}) - signed'({1'b0, pointer.pointer_y});
			last_x_q <= pointer.pointer_x;
			last_y_q <= pointer.pointer_y;
		end
		case (state_q)
			ST_MDY:   red_q <= ysum[VW-1:0];
			ST_RED:   red_q <= red_nx;
			ST_T2:    qa_q  <= p_q[DIV45_SHIFT+10:DIV45_SHIFT];
			ST_CWAIT: begin
				if (csts.done) begin
					if (sel_q) begin
						cy_q <= csts.cosv;
						sy_q <= csts.sinv;
					end else begin
						cp_q <= csts.cosv;
						sp_q <= csts.sinv;
					end
				end
			end
			ST_MZ:    dirx_q <= sat14(rx);
			default: begin
			end
		endcase
		if (load_out) begin
			o_dx_q    <= dirx_q;
			o_dy_q    <= sat14(ry);
			o_dz_q    <= sat14(rx);
			o_yaw_q   <= yaw_q;
			o_pitch_q <= pitch_q;
		end
	end

`ifndef SYNTHESIS
	a_yaw_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		yaw_q < 17'(YAW_FULL))
		else $error("yaw outside one turn");

	a_red_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RED && k_q == '0) |=> (red_q < VW'(YAW_FULL)))
		else $error("yaw reduction left a value above one turn");

	a_pitch_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (pitch_q <= 16'sd23040 && pitch_q >= -16'sd23040))
		else $error("pitch beyond ninety degrees at result");

	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		csts.done |-> (state_q == ST_CWAIT))
		else $error("cordic finished outside its wait state");
`endif

endmodule

@@ hdl/mld_cordic.sv @@
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q1.30.
// Returns cos and sin after quadrant fix-up. Depends on mld_pkg.
module mld_cordic import mld_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mld_cmd_t cmd,
	output mld_sts_t sts
);

	localparam int IW = $clog2(STEPS);

	logic               busy_q;
	logic               done_q;
	logic [IW-1:0]      i_q;
	logic signed [32:0] x_q;
	logic signed [32:0] y_q;
	logic signed [33:0] z_q;
	logic [1:0]         quad_q;

	logic signed [32:0] xs;
	logic signed [32:0] ys;
	logic signed [33:0] atn;
	logic signed [32:0] nx;
	logic signed [32:0] ny;

	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign atn = signed'({4'b0, atan_turn(ATAN_IW'(i_q))});
	assign nx  = -x_q;
	assign ny  = -y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q    <= 33'(CORDIC_GAIN);
			y_q    <= '0;
			z_q    <= 34'(cmd.z);
			quad_q <= cmd.quad;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atn;
			end
		end
	end

	always_comb begin
		sts.done = done_q;
		case (quad_q)
			2'd0: begin
				sts.cosv = x_q[31:0];
				sts.sinv = y_q[31:0];
			end
			2'd1: begin
				sts.cosv = ny[31:0];
				sts.sinv = x_q[31:0];
			end
			2'd2: begin
				sts.cosv = nx[31:0];
				sts.sinv = ny[31:0];
			end
			default: begin
				sts.cosv = y_q[31:0];
				sts.sinv = nx[31:0];
			end
		endcase
	end

endmodule

@@ bench/mouse_look_direction_test.sv @@
// Testbench for mouse_look_direction: drives pointer words and register writes,
// predicts each view word in fixed point and checks every field as it arrives.
// Depends on mld_pkg, mld_ifs and the mouse_look_direction RTL.
`timescale 1ns / 100ps

module mouse_look_direction_test;
	import mld_pkg::*;

	localparam int POS_BITS      = 12;
	localparam int CORDIC_STEPS  = 16;
	localparam int POS_MAX       = (1 << POS_BITS) - 1;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 2 * CORDIC_STEPS + POS_BITS + 9 + 16;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS   = 100;
	localparam int HOLD_CYCLES   = 400;

	localparam int SENS_RESET = 1311;
	localparam int PLIM_RESET = 22784;
	localparam int LAST_X_RESET = 320;
	localparam int LAST_Y_RESET = 240;

	typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [16:0]        yaw_now;
		logic signed [15:0] pitch_now;
	} view_word_t;

	logic clk;
	logic arst_n;

	mld_ptr_if #(.POS_BITS(POS_BITS)) ptr_ch ();
	mld_cfg_if cfg_ch ();
	mld_res_if res_ch ();

	mouse_look_direction #(
		.POS_BITS(POS_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pointer(ptr_ch),
		.cfg(cfg_ch),
		.result(res_ch)
	);

	// atan(2^-i) in 2^32 per turn
	longint turn_atan [TABLE_LEN] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	// camera state mirror
	logic [15:0]         sens_q16     = 16'(SENS_RESET);
	logic [14:0]         pitch_lim    = 15'(PLIM_RESET);
	logic [POS_BITS-1:0] last_x       = POS_BITS'(LAST_X_RESET);
	logic [POS_BITS-1:0] last_y       = POS_BITS'(LAST_Y_RESET);
	logic                first_pending = 1'b1;
	int                  yaw_deg256   = 0;
	int                  pitch_deg256 = 0;

	view_word_t          expected_views [$];
	view_word_t          want;
	logic [POS_BITS-1:0] cur_x;
	logic [POS_BITS-1:0] cur_y;
	bit                  steady;
	int                  rx_hold;
	int                  rx_stall;
	int                  cycle_count;
	int                  errors;
	int                  words_sent;
	int                  views_checked;
	int                  reg_writes;

	function automatic int wrap_angle(input longint v);
		longint r;
		r = v % YAW_FULL;
		if (r < 0)
			r += YAW_FULL;
		return int'(r);
	endfunction

	// cos and sin in Q1.30 of an angle in 1/256 degree
	function automatic void turn_sin_cos(input int ang, output longint c, output longint s);
		longint unsigned a;
		logic [31:0]     turn;
		logic [31:0]     rest;
		quadrant_t       quad;
		longint          x;
		longint          y;
		longint          z;
		longint          nx;
		a = longint'(wrap_angle(ang));
		turn = 32'((a << 32) / longint'(YAW_FULL));
		quad = quadrant_t'(2'((64'(turn) + 64'h2000_0000) >> 30));
		rest = turn - {quad, 30'd0};
		z = $signed(rest);
		x = CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - turn_atan[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + turn_atan[i];
			end
			x = nx;
		end
		case (quad)
			QUAD_0: begin
				c = x;
				s = y;
			end
			QUAD_90: begin
				c = -y;
				s = x;
			end
			QUAD_180: begin
				c = -x;
				s = -y;
			end
			default: begin
				c = y;
				s = -x;
			end
		endcase
	endfunction

	function automatic logic signed [15:0] round_q14(input longint v, input int sh);
		longint r;
		r = (v + (longint'(1) << (sh - 1))) >>> sh;
		if (r > ONE_Q14)
			r = ONE_Q14;
		if (r < -ONE_Q14)
			r = -ONE_Q14;
		return 16'(r);
	endfunction

	function automatic view_word_t advance_view(input logic [POS_BITS-1:0] px,
		input logic [POS_BITS-1:0] py);
		view_word_t v;
		longint     dx;
		longint     dy;
		longint     lim;
		longint     p;
		longint     cp;
		longint     sp;
		longint     cy;
		longint     sy;
		if (first_pending) begin
			last_x = px;
			last_y = py;
			first_pending = 1'b0;
		end
		dx = longint'(px) - longint'(last_x);
		dy = longint'(last_y) - longint'(py);
		last_x = px;
		last_y = py;
		dx = (dx * longint'(sens_q16) + 128) >>> 8;
		dy = (dy * longint'(sens_q16) + 128) >>> 8;
		yaw_deg256 = wrap_angle(longint'(yaw_deg256) + dx);
		lim = (pitch_lim > PITCH_MAX) ? PITCH_MAX : longint'(pitch_lim);
		p = longint'(pitch_deg256) + dy;
		if (p > lim)
			p = lim;
		if (p < -lim)
			p = -lim;
		pitch_deg256 = int'(p);
		turn_sin_cos(pitch_deg256, cp, sp);
		turn_sin_cos(yaw_deg256, cy, sy);
		v.dir_x = round_q14(cp * cy, 46);
		v.dir_y = round_q14(sp, 16);
		v.dir_z = round_q14(cp * sy, 46);
		v.yaw_now = 17'(yaw_deg256);
		v.pitch_now = 16'(pitch_deg256);
		return v;
	endfunction

	function automatic int pause_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [POS_BITS-1:0] nudge(input logic [POS_BITS-1:0] pos);
		int t;
		t = int'(pos) + int'($urandom_range(0, 80)) - 40;
		if (t < 0)
			t = 0;
		if (t > POS_MAX)
			t = POS_MAX;
		return POS_BITS'(t);
	endfunction

	task automatic check_field(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endtask

	// leaves valid high so back-to-back words need no second assignment in one step
	task automatic send_pointer(input logic [POS_BITS-1:0] px, input logic [POS_BITS-1:0] py);
		int gap;
		gap = steady ? 0 : pause_len();
		if (gap > 0) begin
			ptr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ptr_ch.valid <= 1'b1;
		ptr_ch.pointer_x <= px;
		ptr_ch.pointer_y <= py;
		do @(posedge clk); while (!ptr_ch.ready);
		expected_views.push_back(advance_view(px, py));
		words_sent++;
		cur_x = px;
		cur_y = py;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		reg_writes++;
		case (idx)
			CFG_SENS:   sens_q16 = data[15:0];
			CFG_PLIM:   pitch_lim = data[14:0];
			CFG_IYAW:   yaw_deg256 = wrap_angle(longint'(data));
			CFG_IPITCH: pitch_deg256 = $signed(data[15:0]);
			default: ;
		endcase
	endtask

	task automatic load_regs(input logic [CFG_DATA_W-1:0] sens,
		input logic [CFG_DATA_W-1:0] plim, input logic [CFG_DATA_W-1:0] yaw0,
		input logic [CFG_DATA_W-1:0] pitch0);
		write_reg(CFG_SENS, sens);
		write_reg(CFG_PLIM, plim);
		write_reg(CFG_IYAW, yaw0);
		write_reg(CFG_IPITCH, pitch0);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		ptr_ch.valid <= 1'b0;
		wait (expected_views.size() == 0);
	endtask

	// first word after reset records position only; then full-scale jumps
	task automatic test_first_word();
		send_pointer(POS_BITS'(2000), POS_BITS'(1000));
		send_pointer('1, '1);
		send_pointer('0, '0);
		send_pointer('1, '0);
		send_pointer('0, '1);
		settle();
	endtask

	task automatic test_register_extremes();
		for (int i = int'(CFG_IPITCH) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		// max sensitivity, limit above 90 deg, oversized yaw, most negative pitch
		load_regs('1, '1, '1, 17'h18000);
		send_pointer('0, '0);
		send_pointer('1, '1);
		send_pointer('0, '1);
		send_pointer('1, '0);
		settle();
		// zero sensitivity and limit, yaw of exactly one turn, largest pitch
		load_regs(17'h10000, 17'h18000, 17'(YAW_FULL), 17'h07FFF);
		send_pointer('0, '1);
		send_pointer('1, '0);
		settle();
	endtask

	// yaw on each octant boundary, pitch at assorted values, no motion
	task automatic test_octants();
		int tilt [8] = '{0, 11520, -11520, 23040, -23040, 22784, -22784, 1};
		for (int k = 0; k < 8; k++) begin
			load_regs('0, 17'(PITCH_MAX), 17'(k * YAW_FULL / 8), 17'(tilt[k]));
			send_pointer(POS_BITS'($urandom), POS_BITS'($urandom));
			settle();
		end
		load_regs('0, 17'(PITCH_MAX), 17'(YAW_FULL - 1), '0);
		send_pointer(POS_BITS'($urandom), POS_BITS'($urandom));
		settle();
	endtask

	// result sink holds off while words keep coming, so the input stalls
	task automatic test_backpressure();
		load_regs(17'(SENS_RESET), 17'(PLIM_RESET), 17'($urandom_range(0, YAW_FULL - 1)), '0);
		steady = 1'b1;
		rx_hold = HOLD_CYCLES;
		repeat (6)
			send_pointer(nudge(cur_x), nudge(cur_y));
		settle();
		steady = 1'b0;
	endtask

	task automatic test_random_moves(input int phase);
		logic [15:0] sens;
		logic [14:0] plim;
		logic [16:0] pitch0;
		logic [POS_BITS-1:0] nx;
		logic [POS_BITS-1:0] ny;
		case (phase)
			0: begin
				sens = 16'($urandom_range(500, 3000));
				plim = 15'($urandom_range(0, PITCH_MAX));
			end
			1: begin
				sens = 16'($urandom);
				plim = 15'($urandom_range(PITCH_MAX, 32767));
			end
			2: begin
				sens = '1;
				plim = 15'(PITCH_MAX);
			end
			3: begin
				sens = 16'($urandom_range(0, 255));
				plim = '0;
			end
			default: begin
				sens = 16'($urandom);
				plim = 15'($urandom);
			end
		endcase
		if ($urandom_range(0, 1) != 0)
			pitch0 = 17'($urandom);
		else
			pitch0 = 17'($urandom_range(0, 2 * PLIM_RESET) - PLIM_RESET);
		load_regs({1'($urandom), sens}, {2'($urandom), plim}, 17'($urandom), pitch0);
		steady = (phase == 4);
		for (int n = 0; n < PHASE_WORDS; n++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					nx = POS_BITS'($urandom);
					ny = POS_BITS'($urandom);
				end
				2: begin
					nx = ($urandom_range(0, 1) != 0) ? '1 : '0;
					ny = ($urandom_range(0, 1) != 0) ? '1 : '0;
				end
				default: begin
					nx = nudge(cur_x);
					ny = nudge(cur_y);
				end
			endcase
			send_pointer(nx, ny);
		end
		settle();
		steady = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result sink: random stalls, plus an optional long hold
	initial begin
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				res_ch.ready <= 1'b0;
				rx_hold--;
			end else if (rx_stall > 0) begin
				res_ch.ready <= 1'b0;
				rx_stall--;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				rx_stall = pause_len();
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d view words pending",
				cycle_count, expected_views.size());
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_views.size() == 0) begin
				$error("view word arrived with none pending");
				errors++;
			end else begin
				want = expected_views.pop_front();
				check_field("dir_x", want.dir_x, res_ch.dir_x);
				check_field("dir_y", want.dir_y, res_ch.dir_y);
				check_field("dir_z", want.dir_z, res_ch.dir_z);
				check_field("yaw_now", want.yaw_now, res_ch.yaw_now);
				check_field("pitch_now", want.pitch_now, res_ch.pitch_now);
				views_checked++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		ptr_ch.valid = 1'b0;
		ptr_ch.pointer_x = '0;
		ptr_ch.pointer_y = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_SENS;
		cfg_ch.data = '0;
		cur_x = POS_BITS'(LAST_X_RESET);
		cur_y = POS_BITS'(LAST_Y_RESET);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_word();
		test_register_extremes();
		test_octants();
		test_backpressure();
		for (int ph = 0; ph < RANDOM_PHASES; ph++)
			test_random_moves(ph);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d pointer words over directed cases and %0d random phases, %0d reg writes",
			words_sent, RANDOM_PHASES, reg_writes);
		$display("Checked %0d view words, %0d mismatches", views_checked, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/mld_pkg.sv
hdl/mld_ifs.sv
hdl/mld_cordic.sv
hdl/mouse_look_direction.sv
bench/mouse_look_direction_test.sv
